// ===== hw/rtl/iasp_pkg.sv =====
// ----------------------------------------------------------------------------
// iasp_pkg
// Shared types and constants for the IPP attribute stream parser.
// ----------------------------------------------------------------------------
package iasp_pkg;

    // Parser phases
    localparam logic [3:0] PH_HEADER  = 4'd0;
    localparam logic [3:0] PH_TAG     = 4'd1;
    localparam logic [3:0] PH_NLEN_HI = 4'd2;
    localparam logic [3:0] PH_NLEN_LO = 4'd3;
    localparam logic [3:0] PH_NAME    = 4'd4;
    localparam logic [3:0] PH_VLEN_HI = 4'd5;
    localparam logic [3:0] PH_VLEN_LO = 4'd6;
    localparam logic [3:0] PH_VALUE   = 4'd7;
    localparam logic [3:0] PH_AFTER   = 4'd8;

    // Byte classes reported with each result
    localparam logic [3:0] CLS_HEADER = 4'd0;
    localparam logic [3:0] CLS_DELIM  = 4'd1;
    localparam logic [3:0] CLS_TAG    = 4'd2;
    localparam logic [3:0] CLS_NLEN   = 4'd3;
    localparam logic [3:0] CLS_NAME   = 4'd4;
    localparam logic [3:0] CLS_VLEN   = 4'd5;
    localparam logic [3:0] CLS_VALUE  = 4'd6;
    localparam logic [3:0] CLS_END    = 4'd7;
    localparam logic [3:0] CLS_AFTER  = 4'd8;

    // Tags
    localparam logic [7:0] TAG_END       = 8'h03;
    localparam logic [7:0] TAG_DELIM_MAX = 8'h0f;
    localparam logic [7:0] TAG_INTEGER   = 8'h21;
    localparam logic [7:0] TAG_BOOLEAN   = 8'h22;
    localparam logic [7:0] TAG_ENUM      = 8'h23;

    localparam logic [16:0] STATUS_OK_LIMIT = 17'h00100;

    // Header byte positions
    localparam logic [2:0] HDR_STATUS_HI = 3'd2;
    localparam logic [2:0] HDR_STATUS_LO = 3'd3;
    localparam logic [2:0] HDR_LAST      = 3'd7;

    typedef struct packed {
        logic [3:0]         byte_class;
        logic [7:0]         echo_byte;
        logic [7:0]         value_tag;
        logic               additional_value;
        logic               attr_done;
        logic signed [31:0] int_value;
        logic               bool_value;
        logic               truncated;
        logic [15:0]        status_code;
        logic               status_ok;
        logic               result_last;
    } result_t;

endpackage

// ===== hw/rtl/iasp_in_if.sv =====
// ----------------------------------------------------------------------------
// iasp_in_if
// Byte channel into the parser: one message byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface iasp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hw/rtl/iasp_out_if.sv =====
// ----------------------------------------------------------------------------
// iasp_out_if
// Result channel out of the parser: one result per accepted byte.
// ----------------------------------------------------------------------------
interface iasp_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         byte_class;
    logic [7:0]         echo_byte;
    logic [7:0]         value_tag;
    logic               additional_value;
    logic               attr_done;
    logic signed [31:0] int_value;
    logic               bool_value;
    logic               truncated;
    logic [15:0]        status_code;
    logic               status_ok;
    logic               result_last;

    modport source (
        output valid, output byte_class, output echo_byte, output value_tag,
        output additional_value, output attr_done, output int_value,
        output bool_value, output truncated, output status_code,
        output status_ok, output result_last, input ready
    );
    modport sink (
        input valid, input byte_class, input echo_byte, input value_tag,
        input additional_value, input attr_done, input int_value,
        input bool_value, input truncated, input status_code,
        input status_ok, input result_last, output ready
    );
endinterface

// ===== hw/rtl/iasp_core.sv =====
// ----------------------------------------------------------------------------
// iasp_core
// Parser state machine: classifies one byte per advance and forms its result.
// ----------------------------------------------------------------------------
module iasp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output iasp_pkg::result_t res
);

    logic [3:0]  phase_reg,        phase_next;
    logic [2:0]  header_count_reg, header_count_next;
    logic [15:0] remaining_reg,    remaining_next;
    logic [7:0]  length_high_reg,  length_high_next;
    logic [7:0]  current_tag_reg,  current_tag_next;
    logic        name_empty_reg,   name_empty_next;
    logic [31:0] acc_reg,          acc_next;
    logic        first_nz_reg,     first_nz_next;
    logic        seen_reg,         seen_next;
    logic [15:0] status_reg,       status_next;
    logic        value_first_reg,  value_first_next;

    logic [3:0]  cls;
    logic        done;
    logic [15:0] len_word;
    logic        int_tag;

    assign len_word = {length_high_reg, data_byte};

    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        remaining_next    = remaining_reg;
        length_high_next  = length_high_reg;
        current_tag_next  = current_tag_reg;
        name_empty_next   = name_empty_reg;
        acc_next          = acc_reg;
        first_nz_next     = first_nz_reg;
        seen_next         = seen_reg;
        status_next       = status_reg;
        value_first_next  = value_first_reg;
        cls               = iasp_pkg::CLS_HEADER;
        done              = 1'b0;

        case (phase_reg)
            iasp_pkg::PH_HEADER:
            begin
                cls = iasp_pkg::CLS_HEADER;
                if (header_count_reg == iasp_pkg::HDR_STATUS_HI)
                begin
                    length_high_next = data_byte;
                end
                else if (header_count_reg == iasp_pkg::HDR_STATUS_LO)
                begin
                    status_next = len_word;
                end
                if (header_count_reg == iasp_pkg::HDR_LAST)
                begin
                    header_count_next = 3'd0;
                    phase_next        = iasp_pkg::PH_TAG;
                end
                else
                begin
                    header_count_next = header_count_reg + 3'd1;
                end
            end
            iasp_pkg::PH_TAG:
            begin
                if (data_byte == iasp_pkg::TAG_END)
                begin
                    cls        = iasp_pkg::CLS_END;
                    phase_next = iasp_pkg::PH_AFTER;
                end
                else if (data_byte <= iasp_pkg::TAG_DELIM_MAX)
                begin
                    cls = iasp_pkg::CLS_DELIM;
                end
                else
                begin
                    cls              = iasp_pkg::CLS_TAG;
                    current_tag_next = data_byte;
                    phase_next       = iasp_pkg::PH_NLEN_HI;
                end
            end
            iasp_pkg::PH_NLEN_HI:
            begin
                cls              = iasp_pkg::CLS_NLEN;
                length_high_next = data_byte;
                phase_next       = iasp_pkg::PH_NLEN_LO;
            end
            iasp_pkg::PH_NLEN_LO:
            begin
                cls             = iasp_pkg::CLS_NLEN;
                remaining_next  = len_word;
                name_empty_next = (len_word == 16'd0);
                phase_next      = (len_word == 16'd0) ? iasp_pkg::PH_VLEN_HI
                                                      : iasp_pkg::PH_NAME;
            end
            iasp_pkg::PH_NAME:
            begin
                cls            = iasp_pkg::CLS_NAME;
                remaining_next = remaining_reg - 16'd1;
                if (remaining_reg == 16'd1)
                begin
                    phase_next = iasp_pkg::PH_VLEN_HI;
                end
            end
            iasp_pkg::PH_VLEN_HI:
            begin
                cls              = iasp_pkg::CLS_VLEN;
                length_high_next = data_byte;
                phase_next       = iasp_pkg::PH_VLEN_LO;
            end
            iasp_pkg::PH_VLEN_LO:
            begin
                cls              = iasp_pkg::CLS_VLEN;
                remaining_next   = len_word;
                acc_next         = 32'd0;
                first_nz_next    = 1'b0;
                value_first_next = 1'b1;
                if (len_word == 16'd0)
                begin
                    done       = 1'b1;
                    phase_next = iasp_pkg::PH_TAG;
                end
                else
                begin
                    phase_next = iasp_pkg::PH_VALUE;
                end
            end
            iasp_pkg::PH_VALUE:
            begin
                cls      = iasp_pkg::CLS_VALUE;
                acc_next = {acc_reg[23:0], data_byte};
                if (value_first_reg)
                begin
                    first_nz_next    = (data_byte != 8'd0);
                    value_first_next = 1'b0;
                end
                remaining_next = remaining_reg - 16'd1;
                if (remaining_reg == 16'd1)
                begin
                    done       = 1'b1;
                    phase_next = iasp_pkg::PH_TAG;
                end
            end
            default:
            begin
                cls        = iasp_pkg::CLS_AFTER;
                phase_next = iasp_pkg::PH_AFTER;
            end
        endcase

        if (done)
        begin
            seen_next        = 1'b1;
            value_first_next = 1'b0;
        end
    end

    assign int_tag = (current_tag_next == iasp_pkg::TAG_INTEGER)
                  || (current_tag_next == iasp_pkg::TAG_ENUM);

    always_comb
    begin
        res.byte_class       = cls;
        res.echo_byte        = data_byte;
        res.value_tag        = current_tag_next;
        res.additional_value = done & name_empty_reg & seen_reg;
        res.attr_done        = done;
        res.int_value        = (done && int_tag) ? acc_next : 32'sd0;
        res.bool_value       = done && (current_tag_next == iasp_pkg::TAG_BOOLEAN)
                               && first_nz_next;
        res.truncated        = last_byte && (phase_next != iasp_pkg::PH_TAG)
                               && (phase_next != iasp_pkg::PH_AFTER);
        res.status_code      = status_next;
        res.status_ok        = (phase_next != iasp_pkg::PH_HEADER)
                               && ({1'b0, status_next} < iasp_pkg::STATUS_OK_LIMIT);
        res.result_last      = last_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= iasp_pkg::PH_HEADER;
            header_count_reg <= 3'd0;
            remaining_reg    <= 16'd0;
            length_high_reg  <= 8'd0;
            current_tag_reg  <= 8'd0;
            name_empty_reg   <= 1'b0;
            acc_reg          <= 32'd0;
            first_nz_reg     <= 1'b0;
            seen_reg         <= 1'b0;
            status_reg       <= 16'd0;
            value_first_reg  <= 1'b0;
        end
        else if (advance)
        begin
            if (last_byte)
            begin
                // restart for the next message
                phase_reg        <= iasp_pkg::PH_HEADER;
                header_count_reg <= 3'd0;
                remaining_reg    <= 16'd0;
                length_high_reg  <= 8'd0;
                current_tag_reg  <= 8'd0;
                name_empty_reg   <= 1'b0;
                acc_reg          <= 32'd0;
                first_nz_reg     <= 1'b0;
                seen_reg         <= 1'b0;
                status_reg       <= 16'd0;
                value_first_reg  <= 1'b0;
            end
            else
            begin
                phase_reg        <= phase_next;
                header_count_reg <= header_count_next;
                remaining_reg    <= remaining_next;
                length_high_reg  <= length_high_next;
                current_tag_reg  <= current_tag_next;
                name_empty_reg   <= name_empty_next;
                acc_reg          <= acc_next;
                first_nz_reg     <= first_nz_next;
                seen_reg         <= seen_next;
                status_reg       <= status_next;
                value_first_reg  <= value_first_next;
            end
        end
    end

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_byte |=> phase_reg == iasp_pkg::PH_HEADER
                                 && header_count_reg == 3'd0 && !seen_reg)
        else $error("parser did not restart after last byte");

    a_done_in_value_or_len: assert property (@(posedge clk) disable iff (!rst_n)
        res.attr_done |-> res.byte_class == iasp_pkg::CLS_VALUE
                          || res.byte_class == iasp_pkg::CLS_VLEN)
        else $error("attribute completed outside value or value length");

    a_header_count_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        header_count_reg != 3'd0 |-> phase_reg == iasp_pkg::PH_HEADER)
        else $error("header count live outside the header");

    a_value_fields_need_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res.int_value != 32'sd0) || res.bool_value || res.additional_value
            |-> res.attr_done)
        else $error("value fields reported without a completed attribute");

    a_remaining_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == iasp_pkg::PH_NAME || phase_reg == iasp_pkg::PH_VALUE
            |-> remaining_reg != 16'd0)
        else $error("zero remaining length inside name or value");

endmodule

// ===== hw/rtl/iasp_out_reg.sv =====
// ----------------------------------------------------------------------------
// iasp_out_reg
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module iasp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  iasp_pkg::result_t res,
    output logic              space,
    iasp_out_if.source        result_ch
);

    logic              valid_reg;
    iasp_pkg::result_t data_reg;

    // take a new result when empty or when the held one leaves this cycle
    assign space = !valid_reg || result_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (space && load)
        begin
            data_reg <= res;
        end
    end

    assign result_ch.valid            = valid_reg;
    assign result_ch.byte_class       = data_reg.byte_class;
    assign result_ch.echo_byte        = data_reg.echo_byte;
    assign result_ch.value_tag        = data_reg.value_tag;
    assign result_ch.additional_value = data_reg.additional_value;
    assign result_ch.attr_done        = data_reg.attr_done;
    assign result_ch.int_value        = data_reg.int_value;
    assign result_ch.bool_value       = data_reg.bool_value;
    assign result_ch.truncated        = data_reg.truncated;
    assign result_ch.status_code      = data_reg.status_code;
    assign result_ch.status_ok        = data_reg.status_ok;
    assign result_ch.result_last      = data_reg.result_last;

endmodule

// ===== hw/rtl/ipp_attribute_stream_parser_top.sv =====
// ----------------------------------------------------------------------------
// ipp_attribute_stream_parser_top
// IPP response byte stream parser: classifies each byte and reports attributes.
// ----------------------------------------------------------------------------
// A result is registered and valid in the cycle after its byte transaction.
// Throughput: one byte per cycle while the result sink takes results; the state
// update and the result register both load in the cycle of the transaction.
// Reset: asynchronous, active low; the parser starts in the header phase with
// no result pending. The parser also returns to the header phase after every last byte.
// ----------------------------------------------------------------------------
module ipp_attribute_stream_parser_top (
    input  logic       clk,
    input  logic       rst_n,
    iasp_in_if.sink    byte_ch,
    iasp_out_if.source result_ch
);

    logic              space;
    logic              advance;
    iasp_pkg::result_t res;

    assign byte_ch.ready = space;
    assign advance       = byte_ch.valid && space;

    iasp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (byte_ch.data_byte),
        .last_byte (byte_ch.last_byte),
        .res       (res)
    );

    iasp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res       (res),
        .space     (space),
        .result_ch (result_ch)
    );

endmodule
